>>> src/sct_pkg.sv
// shared constants and types for the segment collision test block
// no dependencies; imported by sct_seg, sct_circ and segment_collision_test
`default_nettype none

package sct_pkg;

	localparam int COORD_WIDTH_DEF = 32;
	localparam int FRAC_BITS_DEF   = 16;
	localparam int TOL_W           = 16;
	localparam int NSTG            = 6;
	localparam int CFG_IDX_W       = 3;
	localparam int OUT_TDATA_W     = 8;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_SEG_START_X = 3'd0,
		CFG_SEG_START_Y = 3'd1,
		CFG_SEG_END_X   = 3'd2,
		CFG_SEG_END_Y   = 3'd3,
		CFG_TOLERANCE   = 3'd4
	} cfg_idx_t;

	// per-stage load enables, stage 1 first
	typedef logic [NSTG:1] stg_en_t;

endpackage

`default_nettype wire

>>> src/sct_mul.sv
// two-stage signed multiplier for wide operands: four registered partial
// products, then a registered sum; no package dependencies
`default_nettype none

module sct_mul #(
	parameter int AW = 36,
	parameter int BW = 36
) (
	input  wire logic                  clk,
	input  wire logic                  en_pp,
	input  wire logic                  en_sum,
	input  wire logic signed [AW-1:0]  a,
	input  wire logic signed [BW-1:0]  b,
	output logic signed [AW+BW-1:0]    p
);

	localparam int HA = AW / 2;
	localparam int HB = BW / 2;
	localparam int PW = AW + BW;

	logic [HA-1:0]              a_lo;
	logic signed [AW-HA-1:0]    a_hi;
	logic [HB-1:0]              b_lo;
	logic signed [BW-HB-1:0]    b_hi;

	logic signed [PW-HA-HB-1:0] hh_s1;
	logic signed [AW-HA+HB:0]   hl_s1;
	logic signed [HA+BW-HB:0]   lh_s1;
	logic [HA+HB-1:0]           ll_s1;

	logic [PW-1:0] t_hh, t_hl, t_lh, t_ll;

	assign a_lo = a[HA-1:0];
	assign a_hi = a[AW-1:HA];
	assign b_lo = b[HB-1:0];
	assign b_hi = b[BW-1:HB];

	always_ff @(posedge clk) begin
		if (en_pp) begin
			hh_s1 <= a_hi * b_hi;
			hl_s1 <= a_hi * $signed({1'b0, b_lo});
			lh_s1 <= $signed({1'b0, a_lo}) * b_hi;
			ll_s1 <= a_lo * b_lo;
		end
	end

	// extend each term to full width first, then a plain modular sum
	assign t_hh = PW'(hh_s1) << (HA + HB);
	assign t_hl = PW'(hl_s1) << HA;
	assign t_lh = PW'(lh_s1) << HB;
	assign t_ll = PW'(ll_s1);

	always_ff @(posedge clk) begin
		if (en_sum) begin
			p <= $signed(t_hh + t_hl + t_lh + t_ll);
		end
	end

endmodule

`default_nettype wire

>>> src/sct_seg.sv
// segment-vs-segment datapath: differences, products, cross products,
// straddle products and final decision; uses sct_pkg and sct_mul
`default_nettype none

module sct_seg #(
	parameter int W = sct_pkg::COORD_WIDTH_DEF,
	parameter int F = sct_pkg::FRAC_BITS_DEF
) (
	input  wire logic                         clk,
	input  wire sct_pkg::stg_en_t             en,
	input  wire logic signed [W-1:0]          sx,
	input  wire logic signed [W-1:0]          sy,
	input  wire logic signed [W-1:0]          ex,
	input  wire logic signed [W-1:0]          ey,
	input  wire logic [sct_pkg::TOL_W-1:0]    tol,
	input  wire logic signed [W-1:0]          x0,
	input  wire logic signed [W-1:0]          y0,
	input  wire logic signed [W-1:0]          x1,
	input  wire logic signed [W-1:0]          y1,
	output logic                              hit
);

	import sct_pkg::*;

	localparam int D   = W + 1;
	localparam int M   = 2 * D;
	localparam int X   = 2 * D + 1;
	localparam int PW  = 2 * X;
	localparam int EW1 = TOL_W + F;
	localparam int CW1 = ((X > EW1) ? X : EW1) + 1;
	localparam int EW3 = TOL_W + 3 * F;
	localparam int CW3 = ((PW > EW3) ? PW : EW3) + 1;
	localparam int SW  = ((X > 2 * TOL_W) ? X : 2 * TOL_W) + 1;

	// stage 1
	logic signed [W-1:0] mnx, mxx, mny, mxy, mnpx, mxpx, mnpy, mxpy;
	logic signed [D-1:0] dsx_s1, dsy_s1, dpx_s1, dpy_s1;
	logic signed [D-1:0] a0x_s1, a0y_s1, b0x_s1, b0y_s1;
	logic signed [D-1:0] a1x_s1, a1y_s1, b1x_s1, b1y_s1;
	logic                inb0_s1, inb1_s1, ovl_s1;

	// stage 2
	logic signed [M-1:0] sxx_s2, syy_s2, pxx_s2, pyy_s2;
	logic signed [M-1:0] o0a_s2, o0b_s2, o1a_s2, o1b_s2;
	logic signed [M-1:0] c1a_s2, c1b_s2, c2a_s2, c2b_s2;
	logic signed [M-1:0] c3a_s2, c3b_s2, c4a_s2, c4b_s2;
	logic                inb0_s2, inb1_s2, ovl_s2;

	// stage 3
	logic signed [X-1:0] sls_s3, slp_s3, cr0_s3, cr1_s3;
	logic signed [X-1:0] c1_s3, c2_s3, c3_s3, c4_s3;
	logic                inb0_s3, inb1_s3, ovl_s3;

	// stage 4 and 5
	logic                degen_s4, on_s4, ovl_s4;
	logic                degen_s5, on_s5, ovl_s5;
	logic signed [PW-1:0] p12, p34;

	// stage 6
	logic                hit_s6;

	logic [2*TOL_W-1:0]    eps2;
	logic [EW1-1:0]        e1;
	logic [EW3-1:0]        e3;
	logic signed [SW-1:0]  eps2_w, sls_w, slp_w;
	logic signed [CW1-1:0] e1_w, cr0_w, cr1_w;
	logic signed [CW3-1:0] e3_w, p12_w, p34_w;
	logic                  on0, on1, lt12, lt34;

	always_comb begin
		mnx  = (sx < ex) ? sx : ex;
		mxx  = (sx < ex) ? ex : sx;
		mny  = (sy < ey) ? sy : ey;
		mxy  = (sy < ey) ? ey : sy;
		mnpx = (x0 < x1) ? x0 : x1;
		mxpx = (x0 < x1) ? x1 : x0;
		mnpy = (y0 < y1) ? y0 : y1;
		mxpy = (y0 < y1) ? y1 : y0;
	end

	always_ff @(posedge clk) begin
		if (en[1]) begin
			dsx_s1  <= D'(ex) - D'(sx);
			dsy_s1  <= D'(ey) - D'(sy);
			dpx_s1  <= D'(x1) - D'(x0);
			dpy_s1  <= D'(y1) - D'(y0);
			a0x_s1  <= D'(sx) - D'(x0);
			a0y_s1  <= D'(sy) - D'(y0);
			b0x_s1  <= D'(ex) - D'(x0);
			b0y_s1  <= D'(ey) - D'(y0);
			a1x_s1  <= D'(sx) - D'(x1);
			a1y_s1  <= D'(sy) - D'(y1);
			b1x_s1  <= D'(ex) - D'(x1);
			b1y_s1  <= D'(ey) - D'(y1);
			inb0_s1 <= (x0 >= mnx) && (x0 <= mxx) && (y0 >= mny) && (y0 <= mxy);
			inb1_s1 <= (x1 >= mnx) && (x1 <= mxx) && (y1 >= mny) && (y1 <= mxy);
			ovl_s1  <= (mnx < mxpx) && (mnpx < mxx) && (mny < mxpy) && (mnpy < mxy);
		end
	end

	always_ff @(posedge clk) begin
		if (en[2]) begin
			sxx_s2  <= dsx_s1 * dsx_s1;
			syy_s2  <= dsy_s1 * dsy_s1;
			pxx_s2  <= dpx_s1 * dpx_s1;
			pyy_s2  <= dpy_s1 * dpy_s1;
			o0a_s2  <= a0x_s1 * b0y_s1;
			o0b_s2  <= a0y_s1 * b0x_s1;
			o1a_s2  <= a1x_s1 * b1y_s1;
			o1b_s2  <= a1y_s1 * b1x_s1;
			c1a_s2  <= dsy_s1 * a0x_s1;
			c1b_s2  <= dsx_s1 * a0y_s1;
			c2a_s2  <= dsy_s1 * a1x_s1;
			c2b_s2  <= dsx_s1 * a1y_s1;
			c3a_s2  <= dpx_s1 * a0y_s1;
			c3b_s2  <= dpy_s1 * a0x_s1;
			c4a_s2  <= dpx_s1 * b0y_s1;
			c4b_s2  <= dpy_s1 * b0x_s1;
			inb0_s2 <= inb0_s1;
			inb1_s2 <= inb1_s1;
			ovl_s2  <= ovl_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en[3]) begin
			sls_s3  <= X'(sxx_s2) + X'(syy_s2);
			slp_s3  <= X'(pxx_s2) + X'(pyy_s2);
			cr0_s3  <= X'(o0a_s2) - X'(o0b_s2);
			cr1_s3  <= X'(o1a_s2) - X'(o1b_s2);
			c1_s3   <= X'(c1a_s2) - X'(c1b_s2);
			c2_s3   <= X'(c2a_s2) - X'(c2b_s2);
			c3_s3   <= X'(c3a_s2) - X'(c3b_s2);
			c4_s3   <= X'(c4a_s2) - X'(c4b_s2);
			inb0_s3 <= inb0_s2;
			inb1_s3 <= inb1_s2;
			ovl_s3  <= ovl_s2;
		end
	end

	assign eps2   = tol * tol;
	assign e1     = {tol, {F{1'b0}}};
	assign e3     = {tol, {(3 * F){1'b0}}};
	assign eps2_w = SW'(eps2);
	assign sls_w  = SW'(sls_s3);
	assign slp_w  = SW'(slp_s3);
	assign e1_w   = CW1'(e1);
	assign cr0_w  = CW1'(cr0_s3);
	assign cr1_w  = CW1'(cr1_s3);

	// endpoint lies on the configured segment: small cross product, inside its box
	assign on0 = (cr0_w <= e1_w) && (cr0_w >= -e1_w) && inb0_s3;
	assign on1 = (cr1_w <= e1_w) && (cr1_w >= -e1_w) && inb1_s3;

	always_ff @(posedge clk) begin
		if (en[4]) begin
			degen_s4 <= (sls_w <= eps2_w) || (slp_w <= eps2_w);
			on_s4    <= on0 || on1;
			ovl_s4   <= ovl_s3;
		end
	end

	sct_mul #(.AW(X), .BW(X)) u_mul12 (
		.clk    (clk),
		.en_pp  (en[4]),
		.en_sum (en[5]),
		.a      (c1_s3),
		.b      (c2_s3),
		.p      (p12)
	);

	sct_mul #(.AW(X), .BW(X)) u_mul34 (
		.clk    (clk),
		.en_pp  (en[4]),
		.en_sum (en[5]),
		.a      (c3_s3),
		.b      (c4_s3),
		.p      (p34)
	);

	always_ff @(posedge clk) begin
		if (en[5]) begin
			degen_s5 <= degen_s4;
			on_s5    <= on_s4;
			ovl_s5   <= ovl_s4;
		end
	end

	assign e3_w  = CW3'(e3);
	assign p12_w = CW3'(p12);
	assign p34_w = CW3'(p34);
	assign lt12  = p12_w < -e3_w;
	assign lt34  = p34_w < -e3_w;

	always_ff @(posedge clk) begin
		if (en[6]) begin
			hit_s6 <= !degen_s5 && (on_s5 || (ovl_s5 && lt12 && lt34));
		end
	end

	assign hit = hit_s6;

endmodule

`default_nettype wire

>>> src/sct_circ.sv
// segment-vs-circle datapath: endpoint inside tests and the quadratic
// root test on the configured segment; uses sct_pkg and sct_mul
`default_nettype none

module sct_circ #(
	parameter int W = sct_pkg::COORD_WIDTH_DEF,
	parameter int F = sct_pkg::FRAC_BITS_DEF
) (
	input  wire logic                         clk,
	input  wire sct_pkg::stg_en_t             en,
	input  wire logic signed [W-1:0]          sx,
	input  wire logic signed [W-1:0]          sy,
	input  wire logic signed [W-1:0]          ex,
	input  wire logic signed [W-1:0]          ey,
	input  wire logic [sct_pkg::TOL_W-1:0]    tol,
	input  wire logic signed [W-1:0]          cx,
	input  wire logic signed [W-1:0]          cy,
	input  wire logic [W-2:0]                 r,
	output logic                              hit
);

	import sct_pkg::*;

	localparam int D   = W + 1;
	localparam int M   = 2 * D;
	localparam int X   = 2 * D + 1;
	localparam int RW  = W - 1;
	localparam int BBW = 2 * (X + 1);
	localparam int ACW = 2 * X + 1;
	localparam int DW  = ((BBW > ACW + 2) ? BBW : ACW + 2) + 1;
	localparam int EW3 = TOL_W + 3 * F;
	localparam int CMW = ((DW > EW3) ? DW : EW3) + 1;
	localparam int SW  = X + 3;

	logic signed [D-1:0]   dx_s1, dy_s1, qx_s1, qy_s1, ux_s1, uy_s1;
	logic [RW-1:0]         r_s1;

	logic signed [M-1:0]   dxx_s2, dyy_s2, qxx_s2, qyy_s2, uxx_s2, uyy_s2, dxq_s2, dyq_s2;
	logic [2*RW-1:0]       r2_s2;

	logic signed [X-1:0]   a_s3;
	logic signed [X:0]     b_s3, c_s3, cu_s3;

	logic                  in_s4, anz_s4, cz_s4, abcz_s4, bnp_s4, b2a_s4;
	logic                  in_s5, anz_s5, cz_s5, abcz_s5, bnp_s5, b2a_s5;
	logic signed [BBW-1:0] bb;
	logic signed [ACW-1:0] ac;
	logic                  hit_s6;

	logic signed [X-1:0]   dot;
	logic signed [X:0]     qxx_w, qyy_w, uxx_w, uyy_w, r2_w;
	logic signed [SW-1:0]  a_w, b_w, c_w, b2a_w;
	logic [EW3-1:0]        e3;
	logic signed [CMW-1:0] bb_w, ac_w, e3_w;
	logic                  dlt;

	always_ff @(posedge clk) begin
		if (en[1]) begin
			dx_s1 <= D'(ex) - D'(sx);
			dy_s1 <= D'(ey) - D'(sy);
			qx_s1 <= D'(sx) - D'(cx);
			qy_s1 <= D'(sy) - D'(cy);
			ux_s1 <= D'(ex) - D'(cx);
			uy_s1 <= D'(ey) - D'(cy);
			r_s1  <= r;
		end
	end

	always_ff @(posedge clk) begin
		if (en[2]) begin
			dxx_s2 <= dx_s1 * dx_s1;
			dyy_s2 <= dy_s1 * dy_s1;
			qxx_s2 <= qx_s1 * qx_s1;
			qyy_s2 <= qy_s1 * qy_s1;
			uxx_s2 <= ux_s1 * ux_s1;
			uyy_s2 <= uy_s1 * uy_s1;
			dxq_s2 <= dx_s1 * qx_s1;
			dyq_s2 <= dy_s1 * qy_s1;
			r2_s2  <= r_s1 * r_s1;
		end
	end

	assign dot   = X'(dxq_s2) + X'(dyq_s2);
	assign qxx_w = (X + 1)'(qxx_s2);
	assign qyy_w = (X + 1)'(qyy_s2);
	assign uxx_w = (X + 1)'(uxx_s2);
	assign uyy_w = (X + 1)'(uyy_s2);
	assign r2_w  = (X + 1)'(r2_s2);

	// a = |d|^2, b = 2 d.q, c = |q|^2 - r^2; cu is the same for the end point
	always_ff @(posedge clk) begin
		if (en[3]) begin
			a_s3  <= X'(dxx_s2) + X'(dyy_s2);
			b_s3  <= {dot, 1'b0};
			c_s3  <= qxx_w + qyy_w - r2_w;
			cu_s3 <= uxx_w + uyy_w - r2_w;
		end
	end

	assign a_w   = SW'(a_s3);
	assign b_w   = SW'(b_s3);
	assign c_w   = SW'(c_s3);
	assign b2a_w = b_w + (a_w <<< 1);

	always_ff @(posedge clk) begin
		if (en[4]) begin
			in_s4   <= c_s3[X] || cu_s3[X];
			anz_s4  <= a_s3 != '0;
			cz_s4   <= c_s3 == '0;
			abcz_s4 <= (a_w + b_w + c_w) == '0;
			bnp_s4  <= b_s3[X] || (b_s3 == '0);
			b2a_s4  <= !b2a_w[SW-1];
		end
	end

	sct_mul #(.AW(X + 1), .BW(X + 1)) u_mul_bb (
		.clk    (clk),
		.en_pp  (en[4]),
		.en_sum (en[5]),
		.a      (b_s3),
		.b      (b_s3),
		.p      (bb)
	);

	sct_mul #(.AW(X), .BW(X + 1)) u_mul_ac (
		.clk    (clk),
		.en_pp  (en[4]),
		.en_sum (en[5]),
		.a      (a_s3),
		.b      (c_s3),
		.p      (ac)
	);

	always_ff @(posedge clk) begin
		if (en[5]) begin
			in_s5   <= in_s4;
			anz_s5  <= anz_s4;
			cz_s5   <= cz_s4;
			abcz_s5 <= abcz_s4;
			bnp_s5  <= bnp_s4;
			b2a_s5  <= b2a_s4;
		end
	end

	// discriminant b^2 - 4ac against the tolerance
	assign e3   = {tol, {(3 * F){1'b0}}};
	assign e3_w = CMW'(e3);
	assign bb_w = CMW'(bb);
	assign ac_w = CMW'(ac);
	assign dlt  = (bb_w - (ac_w <<< 2)) < e3_w;

	always_ff @(posedge clk) begin
		if (en[6]) begin
			hit_s6 <= in_s5 ||
				(!dlt && anz_s5 && (cz_s5 || abcz_s5 || (bnp_s5 && b2a_s5)));
		end
	end

	assign hit = hit_s6;

endmodule

`default_nettype wire

>>> src/segment_collision_test.sv
// Segment collision test. A segment and a tolerance are set through the cfg
// channel (index 0..3: start x/y, end x/y; index 4: tolerance). Each query
// item on the s_t* channel is a segment or a circle; every item gives one
// item on m_t* carrying hit in bit 0 of m_tdata.
// A result is offered on m_tvalid once its query item has passed the six
// stages. Throughput: one item per cycle unless m_tready stalls; the stages are
// the differences, the products, the cross product sums, the wide
// straddle/discriminant multiplier (two stages) and the final compare.
// Each stage holds its own valid bit and loads whenever it is empty or the
// next stage moves, so bubbles are squeezed out and s_tready stays high
// while the stalled result waits, until all six stages are full. A stall
// freezes the full stages in place.
// Reset clears all valid bits and sets the segment to zero and the
// tolerance to one. cfg_ready is always high; write only while idle.
// Depends on sct_pkg, sct_seg, sct_circ and sct_mul.
`default_nettype none

module segment_collision_test #(
	parameter int COORD_WIDTH = sct_pkg::COORD_WIDTH_DEF,
	parameter int FRAC_BITS   = sct_pkg::FRAC_BITS_DEF
) (
	input  wire logic                                   clk,
	input  wire logic                                   arst_n,
	input  wire logic                                   s_tvalid,
	output logic                                        s_tready,
	// other_x0, other_y0, other_x1, other_y1, radius, zero fill
	input  wire logic [((5*COORD_WIDTH-1)+7)/8*8-1:0]   s_tdata,
	// opcode, other_valid
	input  wire logic [1:0]                             s_tuser,
	output logic                                        m_tvalid,
	input  wire logic                                   m_tready,
	// hit, zero fill
	output logic [sct_pkg::OUT_TDATA_W-1:0]             m_tdata,
	input  wire logic                                   cfg_valid,
	output logic                                        cfg_ready,
	input  wire logic [sct_pkg::CFG_IDX_W-1:0]          cfg_index,
	input  wire logic [COORD_WIDTH-1:0]                 cfg_data
);

	import sct_pkg::*;

	localparam int W = COORD_WIDTH;

	typedef struct packed {
		logic vld;
		logic op;
		logic ok;
	} ctl_t;

	localparam logic OP_CIRCLE = 1'b1;

	logic signed [W-1:0] seg_sx_q, seg_sy_q, seg_ex_q, seg_ey_q;
	logic [TOL_W-1:0]    tol_q;

	ctl_t    ctl_s [NSTG:1];
	stg_en_t en;

	logic signed [W-1:0] ox0, oy0, ox1, oy1;
	logic [W-2:0]        orad;
	logic                seg_hit, circ_hit, hit;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seg_sx_q <= '0;
			seg_sy_q <= '0;
			seg_ex_q <= '0;
			seg_ey_q <= '0;
			tol_q    <= TOL_W'(1);
		end else if (cfg_valid) begin
			unique case (cfg_idx_t'(cfg_index))
				CFG_SEG_START_X: seg_sx_q <= $signed(cfg_data);
				CFG_SEG_START_Y: seg_sy_q <= $signed(cfg_data);
				CFG_SEG_END_X:   seg_ex_q <= $signed(cfg_data);
				CFG_SEG_END_Y:   seg_ey_q <= $signed(cfg_data);
				CFG_TOLERANCE:   tol_q    <= cfg_data[TOL_W-1:0];
				default: ;
			endcase
		end
	end

	// a stage loads when it is empty or its contents move on
	always_comb begin
		en[NSTG] = !ctl_s[NSTG].vld || m_tready;
		for (int k = NSTG - 1; k >= 1; k--) begin
			en[k] = !ctl_s[k].vld || en[k+1];
		end
	end

	assign s_tready = en[1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 1; k <= NSTG; k++) begin
				ctl_s[k] <= '0;
			end
		end else begin
			if (en[1]) begin
				ctl_s[1] <= '{vld: s_tvalid, op: s_tuser[0], ok: s_tuser[1]};
			end
			for (int k = 2; k <= NSTG; k++) begin
				if (en[k]) begin
					ctl_s[k] <= ctl_s[k-1];
				end
			end
		end
	end

	assign ox0  = $signed(s_tdata[0 +: W]);
	assign oy0  = $signed(s_tdata[W +: W]);
	assign ox1  = $signed(s_tdata[2*W +: W]);
	assign oy1  = $signed(s_tdata[3*W +: W]);
	assign orad = s_tdata[4*W +: W-1];

	sct_seg #(.W(W), .F(FRAC_BITS)) u_seg (
		.clk (clk),
		.en  (en),
		.sx  (seg_sx_q),
		.sy  (seg_sy_q),
		.ex  (seg_ex_q),
		.ey  (seg_ey_q),
		.tol (tol_q),
		.x0  (ox0),
		.y0  (oy0),
		.x1  (ox1),
		.y1  (oy1),
		.hit (seg_hit)
	);

	sct_circ #(.W(W), .F(FRAC_BITS)) u_circ (
		.clk (clk),
		.en  (en),
		.sx  (seg_sx_q),
		.sy  (seg_sy_q),
		.ex  (seg_ex_q),
		.ey  (seg_ey_q),
		.tol (tol_q),
		.cx  (ox0),
		.cy  (oy0),
		.r   (orad),
		.hit (circ_hit)
	);

	assign hit      = ctl_s[NSTG].ok && ((ctl_s[NSTG].op == OP_CIRCLE) ? circ_hit : seg_hit);
	assign m_tvalid = ctl_s[NSTG].vld;
	assign m_tdata  = {{(OUT_TDATA_W-1){1'b0}}, hit};

endmodule

`default_nettype wire
